// File: rtl/dpbb_pkg.sv
// Shared types, constants and helpers for the depth pixel bounding box core.
package dpbb_pkg;

    localparam int INDEX_BITS    = 12;
    localparam int COORD_BITS    = 16;
    localparam int DEPTH_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int DIV_W         = 40;
    localparam int DIV_CNT_BITS  = 6;
    localparam int ROT_W         = 56;

    localparam logic [DEPTH_BITS-1:0] DEPTH_NONE = 8'd0;
    localparam logic [DEPTH_BITS-1:0] DEPTH_SAT  = 8'd255;

    localparam logic [15:0]        RST_DEPTH_SCALE = 16'd256;
    localparam logic [15:0]        RST_TAN_W       = 16'd17793;
    localparam logic [15:0]        RST_TAN_H       = 16'd13507;
    localparam logic signed [15:0] RST_SINE        = 16'sd0;
    localparam logic signed [15:0] RST_COSINE      = 16'sd16384;
    localparam logic signed [10:0] RST_MOUNT       = 11'sd0;
    localparam logic [11:0]        RST_WIDTH       = 12'd640;
    localparam logic [11:0]        RST_HEIGHT      = 12'd480;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEPTH_SCALE = 3'd0,
        CFG_TAN_WIDTH   = 3'd1,
        CFG_TAN_HEIGHT  = 3'd2,
        CFG_TILT_SINE   = 3'd3,
        CFG_TILT_COSINE = 3'd4,
        CFG_MOUNT       = 3'd5,
        CFG_FRAME_W     = 3'd6,
        CFG_FRAME_H     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic [INDEX_BITS-1:0] column;
        logic [INDEX_BITS-1:0] row;
        logic                  last;
    } pixel_t;

    typedef struct packed {
        logic                         found;
        logic signed [COORD_BITS-1:0] near_cm;
        logic signed [COORD_BITS-1:0] far_cm;
        logic signed [COORD_BITS-1:0] left_cm;
        logic signed [COORD_BITS-1:0] right_cm;
        logic signed [COORD_BITS-1:0] bottom_cm;
        logic signed [COORD_BITS-1:0] top_cm;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_LDX,
        ST_DIVX,
        ST_LDY,
        ST_DIVY,
        ST_ROT,
        ST_SUM,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic divx_load;
        logic divy_load;
        logic div_step;
        logic store_x;
        logic store_y;
        logic rot;
        logic sum;
        logic update;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic depth_ok;
        logic last;
        logic div_done;
        logic out_busy;
    } dp_status_t;

    function automatic logic signed [COORD_BITS-1:0] to_cm(input logic signed [ROT_W-1:0] v);
        logic signed [ROT_W-1:0] t;
        logic signed [ROT_W-1:0] hi;
        logic signed [ROT_W-1:0] lo;
        t  = v >>> 8;
        hi = ROT_W'(signed'({1'b0, {(COORD_BITS-1){1'b1}}}));
        lo = ROT_W'(signed'({1'b1, {(COORD_BITS-1){1'b0}}}));
        if (t > hi) begin
            return hi[COORD_BITS-1:0];
        end else if (t < lo) begin
            return lo[COORD_BITS-1:0];
        end
        return t[COORD_BITS-1:0];
    endfunction

endpackage

// File: rtl/dpbb_ctrl.sv
// Sequencer for the per-pixel projection, division and bound update.
module dpbb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dpbb_pkg::dp_status_t  status,
    output dpbb_pkg::dp_cmd_t     cmd
);
    import dpbb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.depth_ok ? ST_MUL1 : ST_FINISH;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = ST_LDX;
            end
            ST_LDX: begin
                cmd.divx_load = 1'b1;
                state_next    = ST_DIVX;
            end
            ST_DIVX: begin
                if (status.div_done) begin
                    cmd.store_x = 1'b1;
                    state_next  = ST_LDY;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_LDY: begin
                cmd.divy_load = 1'b1;
                state_next    = ST_DIVY;
            end
            ST_DIVY: begin
                if (status.div_done) begin
                    cmd.store_y = 1'b1;
                    state_next  = ST_ROT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_ROT: begin
                cmd.rot    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/dpbb_datapath.sv
// Configuration registers, projection arithmetic, serial divider and running bounds.
module dpbb_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [dpbb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [dpbb_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  dpbb_pkg::pixel_t                       s_data,
    input  dpbb_pkg::dp_cmd_t                      cmd,
    output dpbb_pkg::dp_status_t                   status,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output dpbb_pkg::result_t                      m_data
);
    import dpbb_pkg::*;

    logic [15:0]        depth_scale_reg;
    logic [15:0]        tan_w_reg;
    logic [15:0]        tan_h_reg;
    logic signed [15:0] sine_reg;
    logic signed [15:0] cosine_reg;
    logic signed [10:0] mount_reg;
    logic [11:0]        width_reg;
    logic [11:0]        height_reg;

    pixel_t pix_reg;

    logic [11:0]        w_eff;
    logic [11:0]        h_eff;
    logic signed [13:0] dc_next;
    logic signed [13:0] ndr_next;
    logic signed [13:0] dc_reg;
    logic signed [13:0] ndr_reg;
    logic [23:0]        z8_reg;
    logic [39:0]        p1x_reg;
    logic [39:0]        p1y_reg;
    logic signed [39:0] c_reg;
    logic signed [39:0] e_reg;
    logic signed [53:0] prod_x;
    logic signed [53:0] prod_y;
    logic signed [53:0] sh_x;
    logic signed [53:0] sh_y;
    logic signed [39:0] nx_reg;
    logic signed [39:0] ny_reg;

    logic                    div_neg_reg;
    logic                    div_sel_reg;
    logic [DIV_W-1:0]        quo_reg;
    logic [12:0]             rem_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [11:0]             divisor;
    logic [13:0]             shifted;
    logic [14:0]             diff;
    logic signed [DIV_W-1:0] div_num;
    logic signed [DIV_W-1:0] div_q;

    logic signed [DIV_W-1:0] x8_reg;
    logic signed [DIV_W-1:0] y8_reg;
    logic signed [ROT_W-1:0] a_reg;
    logic signed [ROT_W-1:0] b_reg;
    logic signed [ROT_W-1:0] ht_reg;
    logic signed [ROT_W-1:0] dp_reg;
    logic signed [ROT_W-1:0] ht_next;
    logic signed [ROT_W-1:0] dp_next;

    logic signed [COORD_BITS-1:0] x_cm;
    logic signed [COORD_BITS-1:0] h_cm;
    logic signed [COORD_BITS-1:0] d_cm;

    logic                         seen_reg;
    logic signed [COORD_BITS-1:0] min_d_reg;
    logic signed [COORD_BITS-1:0] max_d_reg;
    logic signed [COORD_BITS-1:0] min_x_reg;
    logic signed [COORD_BITS-1:0] max_x_reg;
    logic signed [COORD_BITS-1:0] min_h_reg;
    logic signed [COORD_BITS-1:0] max_h_reg;

    result_t out_reg;
    logic    m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_scale_reg <= RST_DEPTH_SCALE;
            tan_w_reg       <= RST_TAN_W;
            tan_h_reg       <= RST_TAN_H;
            sine_reg        <= RST_SINE;
            cosine_reg      <= RST_COSINE;
            mount_reg       <= RST_MOUNT;
            width_reg       <= RST_WIDTH;
            height_reg      <= RST_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEPTH_SCALE: depth_scale_reg <= cfg_wdata;
                CFG_TAN_WIDTH:   tan_w_reg       <= cfg_wdata;
                CFG_TAN_HEIGHT:  tan_h_reg       <= cfg_wdata;
                CFG_TILT_SINE:   sine_reg        <= signed'(cfg_wdata);
                CFG_TILT_COSINE: cosine_reg      <= signed'(cfg_wdata);
                CFG_MOUNT:       mount_reg       <= signed'(cfg_wdata[10:0]);
                CFG_FRAME_W:     width_reg       <= cfg_wdata[11:0];
                CFG_FRAME_H:     height_reg      <= cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    assign w_eff    = (width_reg == 12'd0) ? 12'd1 : width_reg;
    assign h_eff    = (height_reg == 12'd0) ? 12'd1 : height_reg;
    assign dc_next  = signed'({2'b00, pix_reg.column}) - signed'({3'b000, w_eff[11:1]});
    assign ndr_next = signed'({3'b000, h_eff[11:1]}) - signed'({2'b00, pix_reg.row});

    assign prod_x = 54'(signed'({1'b0, p1x_reg})) * 54'(dc_reg);
    assign prod_y = 54'(signed'({1'b0, p1y_reg})) * 54'(ndr_reg);
    assign sh_x   = prod_x >>> 14;
    assign sh_y   = prod_y >>> 14;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_reg <= s_data;
        end
        if (cmd.mul1) begin
            z8_reg  <= 24'(pix_reg.depth) * 24'(depth_scale_reg);
            dc_reg  <= dc_next;
            ndr_reg <= ndr_next;
        end
        if (cmd.mul2) begin
            p1x_reg <= 40'(tan_w_reg) * 40'(z8_reg);
            p1y_reg <= 40'(tan_h_reg) * 40'(z8_reg);
            c_reg   <= 40'(sine_reg) * signed'({16'd0, z8_reg});
            e_reg   <= 40'(cosine_reg) * signed'({16'd0, z8_reg});
        end
        if (cmd.mul3) begin
            nx_reg <= sh_x[39:0];
            ny_reg <= sh_y[39:0];
        end
    end

    // Restoring divider, one quotient bit per cycle, floor result for negative dividends.
    assign div_num = cmd.divy_load ? ny_reg : nx_reg;
    assign divisor = div_sel_reg ? h_eff : w_eff;
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {3'b000, divisor};
    assign div_q   = !div_neg_reg ? signed'(quo_reg)
                   : (rem_reg != 13'd0) ? signed'(~quo_reg) : signed'(-quo_reg);

    always_ff @(posedge aclk) begin
        if (cmd.divx_load || cmd.divy_load) begin
            div_neg_reg <= div_num[DIV_W-1];
            div_sel_reg <= cmd.divy_load;
            quo_reg     <= div_num[DIV_W-1] ? DIV_W'(-div_num) : DIV_W'(div_num);
            rem_reg     <= '0;
            cnt_reg     <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + DIV_CNT_BITS'(1);
            if (!diff[14]) begin
                rem_reg <= diff[12:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[12:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign ht_next = ((a_reg - ROT_W'(c_reg)) >>> 14) - (ROT_W'(mount_reg) <<< 8);
    assign dp_next = (b_reg + ROT_W'(e_reg)) >>> 14;

    always_ff @(posedge aclk) begin
        if (cmd.store_x) begin
            x8_reg <= div_q;
        end
        if (cmd.store_y) begin
            y8_reg <= div_q;
        end
        if (cmd.rot) begin
            a_reg <= ROT_W'(cosine_reg) * ROT_W'(y8_reg);
            b_reg <= ROT_W'(sine_reg) * ROT_W'(y8_reg);
        end
        if (cmd.sum) begin
            ht_reg <= ht_next;
            dp_reg <= dp_next;
        end
    end

    assign x_cm = to_cm(ROT_W'(x8_reg));
    assign h_cm = to_cm(ht_reg);
    assign d_cm = to_cm(dp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= 1'b0;
            min_d_reg <= '0;
            max_d_reg <= '0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_h_reg <= '0;
            max_h_reg <= '0;
        end else if (cmd.update) begin
            seen_reg <= 1'b1;
            if (!seen_reg || d_cm < min_d_reg) min_d_reg <= d_cm;
            if (!seen_reg || d_cm > max_d_reg) max_d_reg <= d_cm;
            if (!seen_reg || x_cm < min_x_reg) min_x_reg <= x_cm;
            if (!seen_reg || x_cm > max_x_reg) max_x_reg <= x_cm;
            if (!seen_reg || h_cm < min_h_reg) min_h_reg <= h_cm;
            if (!seen_reg || h_cm > max_h_reg) max_h_reg <= h_cm;
        end else if (cmd.emit) begin
            seen_reg  <= 1'b0;
            min_d_reg <= '0;
            max_d_reg <= '0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_h_reg <= '0;
            max_h_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.found     <= seen_reg;
            out_reg.near_cm   <= min_d_reg;
            out_reg.far_cm    <= max_d_reg;
            out_reg.left_cm   <= min_x_reg;
            out_reg.right_cm  <= max_x_reg;
            out_reg.bottom_cm <= min_h_reg;
            out_reg.top_cm    <= max_h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;
    assign status.depth_ok = (pix_reg.depth != DEPTH_NONE) && (pix_reg.depth != DEPTH_SAT);
    assign status.last     = pix_reg.last;
    assign status.div_done = (cnt_reg == DIV_CNT_BITS'(DIV_W));
    assign status.out_busy = m_valid_reg && !m_ready;

endmodule

// File: rtl/depth_pixel_3d_bounding_box_core.sv
// Top level of the depth pixel 3D bounding box core.
// A valid pixel is processed fully before the next one is accepted: three multiply
// steps, then a bit-serial divider that runs once for x and once for y.
// A pixel with depth 0 or 255 skips the arithmetic. After the last pixel, once no
// earlier beat is pending, a result beat is held in an output register until taken.
// Reset restores the register defaults, clears the bounds and drops m_valid.
module depth_pixel_3d_bounding_box_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dpbb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dpbb_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dpbb_pkg::pixel_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dpbb_pkg::result_t                  m_data
);
    import dpbb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dpbb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dpbb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid && !m_ready))
        else $error("result register overwritten while a beat is pending");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !status.div_done)
        else $error("divider stepped past its last quotient bit");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.near_cm == '0 && m_data.top_cm == '0))
        else $error("empty region reported nonzero bounds");

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second pixel accepted before the first finished");

endmodule

// File: tb/testbench.sv
// Testbench for the depth pixel 3D bounding box core: directed and random pixels, predicted bounds.
`timescale 1ns / 1ps

class bbox_scoreboard;
    dpbb_pkg::result_t pending_boxes[$];
    logic [15:0] scale_q88, tan_w, tan_h;
    logic signed [15:0] tilt_sin, tilt_cos;
    logic signed [10:0] mount_cm;
    logic [11:0] width_px, height_px;
    bit have_pixel;
    longint lo_d, hi_d, lo_x, hi_x, lo_h, hi_h;
    int errors;

    function new();
        scale_q88 = 16'd256;
        tan_w = 16'd17793;
        tan_h = 16'd13507;
        tilt_sin = 0;
        tilt_cos = 16'sd16384;
        mount_cm = 0;
        width_px = 12'd640;
        height_px = 12'd480;
        errors = 0;
        clear_box();
    endfunction

    function void clear_box();
        have_pixel = 0;
        lo_d = 0; hi_d = 0; lo_x = 0; hi_x = 0; lo_h = 0; hi_h = 0;
    endfunction

    function void write_reg(dpbb_pkg::cfg_idx_t idx, logic [15:0] v);
        case (idx)
            dpbb_pkg::CFG_DEPTH_SCALE: scale_q88 = v;
            dpbb_pkg::CFG_TAN_WIDTH:   tan_w = v;
            dpbb_pkg::CFG_TAN_HEIGHT:  tan_h = v;
            dpbb_pkg::CFG_TILT_SINE:   tilt_sin = v;
            dpbb_pkg::CFG_TILT_COSINE: tilt_cos = v;
            dpbb_pkg::CFG_MOUNT:       mount_cm = v[10:0];
            dpbb_pkg::CFG_FRAME_W:     width_px = v[11:0];
            dpbb_pkg::CFG_FRAME_H:     height_px = v[11:0];
            default: ;
        endcase
    endfunction

    function longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function longint to_whole_cm(longint v8);
        longint c;
        c = floor_div(v8, 256);
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c;
    endfunction

    function void widen(ref longint lo, ref longint hi, input longint v);
        if (!have_pixel || v < lo) lo = v;
        if (!have_pixel || v > hi) hi = v;
    endfunction

    function void note_pixel(dpbb_pkg::pixel_t p);
        longint w, h, z8, x8, y8, ht8, dp8, dc, dr;
        dpbb_pkg::result_t r;
        if (p.depth != dpbb_pkg::DEPTH_NONE && p.depth != dpbb_pkg::DEPTH_SAT) begin
            w = (width_px == 0) ? 1 : longint'(width_px);
            h = (height_px == 0) ? 1 : longint'(height_px);
            z8 = longint'(p.depth) * longint'(scale_q88);
            dc = longint'(p.column) - w / 2;
            dr = longint'(p.row) - h / 2;
            x8 = floor_div(2 * longint'(tan_w) * z8 * dc, w * 32768);
            y8 = floor_div(-2 * longint'(tan_h) * z8 * dr, h * 32768);
            ht8 = floor_div(longint'(tilt_cos) * y8 - longint'(tilt_sin) * z8, 16384)
                  - longint'(mount_cm) * 256;
            dp8 = floor_div(longint'(tilt_sin) * y8 + longint'(tilt_cos) * z8, 16384);
            widen(lo_x, hi_x, to_whole_cm(x8));
            widen(lo_h, hi_h, to_whole_cm(ht8));
            widen(lo_d, hi_d, to_whole_cm(dp8));
            have_pixel = 1;
        end
        if (p.last) begin
            r.found = have_pixel;
            r.near_cm = lo_d[15:0];
            r.far_cm = hi_d[15:0];
            r.left_cm = lo_x[15:0];
            r.right_cm = hi_x[15:0];
            r.bottom_cm = lo_h[15:0];
            r.top_cm = hi_h[15:0];
            pending_boxes.push_back(r);
            clear_box();
        end
    endfunction

    function void report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endfunction

    function void check_box(dpbb_pkg::result_t got);
        dpbb_pkg::result_t want;
        if (pending_boxes.size() == 0) begin
            report("unexpected beat", 1, 0);
            return;
        end
        want = pending_boxes.pop_front();
        if (got.found !== want.found) report("found", got.found, want.found);
        if (got.near_cm !== want.near_cm) report("near_cm", got.near_cm, want.near_cm);
        if (got.far_cm !== want.far_cm) report("far_cm", got.far_cm, want.far_cm);
        if (got.left_cm !== want.left_cm) report("left_cm", got.left_cm, want.left_cm);
        if (got.right_cm !== want.right_cm) report("right_cm", got.right_cm, want.right_cm);
        if (got.bottom_cm !== want.bottom_cm)
            report("bottom_cm", got.bottom_cm, want.bottom_cm);
        if (got.top_cm !== want.top_cm) report("top_cm", got.top_cm, want.top_cm);
    endfunction
endclass

module testbench;
    import dpbb_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    pixel_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    result_t m_data;

    bbox_scoreboard board;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    depth_pixel_3d_bounding_box_core u_top (.*);

    always @(posedge aclk) begin
        if (s_valid && s_ready) board.note_pixel(s_data);
        if (m_valid && m_ready) board.check_box(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("depth_pixel_3d_bounding_box_core regression: fail");
            $finish;
        end
    end

    initial begin
        int wait_n;
        forever begin
            @(posedge aclk);
            if (!m_ready || (m_valid && m_ready)) begin
                wait_n = $urandom_range(0, 10);
                if (m_valid && m_ready && wait_n != 0) m_ready <= 0;
                repeat (wait_n) @(posedge aclk);
                m_ready <= 1;
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        board.write_reg(idx, v);
    endtask

    task automatic send_pixel(logic [7:0] d, logic [11:0] c, logic [11:0] r, bit l,
                              bit burst);
        pixel_t p;
        int gap;
        gap = burst ? 0 : int'($urandom_range(0, 10));
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        p.depth = d; p.column = c; p.row = r; p.last = l;
        s_valid <= 1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending_boxes.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic random_settings(int mode);
        logic [15:0] v [8];
        if (mode == 0) begin
            v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h4000, 16'hC000, 16'h03FF, 16'd4095,
                  16'd4095};
        end else if (mode == 1) begin
            v = '{16'd0, 16'd0, 16'd0, 16'hC000, 16'h4000, 16'h0400, 16'd1, 16'd1};
        end else if (mode == 2) begin
            v = '{16'd256, 16'd17793, 16'd13507, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0};
        end else begin
            v[0] = 16'($urandom_range(0, 65535));
            v[1] = 16'($urandom_range(0, 65535));
            v[2] = 16'($urandom_range(0, 65535));
            v[3] = 16'($signed($urandom_range(0, 32768)) - 16384);
            v[4] = 16'($signed($urandom_range(0, 32768)) - 16384);
            v[5] = 16'($urandom_range(0, 2047));
            v[6] = 16'($urandom_range(1, 4095));
            v[7] = 16'($urandom_range(1, 4095));
        end
        for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
        cfg_wr_en <= 0;
    endtask

    task automatic random_region(int n);
        bit burst;
        logic [7:0] d;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: d = DEPTH_NONE;
                1: d = DEPTH_SAT;
                default: d = 8'($urandom_range(1, 254));
            endcase
            send_pixel(d, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       i == n - 1, burst);
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_pixel(8'd1, 12'd0, 12'd0, 0, 0);
        send_pixel(8'd254, 12'd4095, 12'd4095, 0, 0);
        send_pixel(DEPTH_NONE, 12'd320, 12'd240, 0, 0);
        send_pixel(8'd128, 12'd320, 12'd240, 1, 0);
        send_pixel(DEPTH_SAT, 12'd5, 12'd5, 1, 0);
        send_pixel(DEPTH_NONE, 12'd5, 12'd5, 1, 0);
        send_pixel(8'd100, 12'd639, 12'd0, 0, 0);
        send_pixel(DEPTH_SAT, 12'd0, 12'd479, 1, 0);
        send_pixel(8'd85, 12'hAAA, 12'h555, 1, 0);
        send_pixel(8'd170, 12'h555, 12'hAAA, 1, 0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            random_settings(ph);
            random_region(3);
            random_region(4);
            send_pixel(8'd254, 12'd0, 12'd4095, 1, 0);
            send_pixel(8'd1, 12'd4095, 12'd0, 1, 0);
            drain();
        end

        for (int ph = 0; ph < 12; ph++) begin
            random_settings(3);
            for (int k = 0; k < 8; k++) random_region($urandom_range(1, 9));
            drain();
        end

        while (board.pending_boxes.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (board.errors == 0) begin
            $display("depth_pixel_3d_bounding_box_core regression: pass");
        end else begin
            $display("depth_pixel_3d_bounding_box_core regression: fail");
        end
        $finish;
    end
endmodule
